// ===== hdl/bqf_pkg.sv =====
package bqf_pkg;

    // Channel and sample format
    localparam int CHANNELS       = 8;
    localparam int CHAN_BITS      = 3;
    localparam int CHAN_AW        = $clog2(CHANNELS);
    localparam int SAMPLE_BITS    = 24;

    // Coefficient and state format
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 24;
    localparam int STATE_BITS     = 40;

    // Digit-serial multiplier geometry
    localparam int DIGIT_BITS     = 8;
    localparam int NDIG           = COEF_BITS / DIGIT_BITS;
    localparam int DIG_BITS       = $clog2(NDIG);
    localparam int MUL_HI_BITS    = STATE_BITS + 1;
    localparam int MUL_T_BITS     = STATE_BITS + DIGIT_BITS + 1;
    localparam int MUL_RND        = 1 << (COEF_FRAC_BITS - 1);

    // Rounded product and sum widths
    localparam int PROD_BITS      = STATE_BITS + COEF_BITS - COEF_FRAC_BITS;
    localparam int ACC_BITS       = PROD_BITS + 3;

    // Operation sequencing: five products per sample in every form
    localparam int NOPS           = 5;
    localparam int OP_BITS        = 3;

    // Sample <-> state alignment
    localparam int TS_SHIFT       = COEF_FRAC_BITS - (SAMPLE_BITS - 1);
    localparam int TS_LEFT        = (TS_SHIFT > 0) ? TS_SHIFT : 0;
    localparam int TS_RIGHT       = (TS_SHIFT < 0) ? -TS_SHIFT : 0;
    localparam int TS_RND         = (TS_LEFT > 0) ? (1 << (TS_LEFT - 1)) : 0;

    localparam logic [CHAN_BITS:0] CHAN_LIMIT = (CHAN_BITS + 1)'(CHANNELS);

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_B0       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_B1       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_B2       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FB1      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FB2      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOPOLOGY = 3'd5;

    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'd1 << COEF_FRAC_BITS);

    typedef logic signed [STATE_BITS-1:0] state_word_t;
    typedef logic signed [COEF_BITS-1:0]  coef_t;

    typedef enum logic [1:0] {
        TOPO_DF1  = 2'd0,
        TOPO_DF2  = 2'd1,
        TOPO_TDF1 = 2'd2,
        TOPO_TDF2 = 2'd3
    } topo_t;

    // One channel's delay state
    typedef struct packed {
        state_word_t in1;
        state_word_t in2;
        state_word_t out1;
        state_word_t out2;
        state_word_t mid1;
        state_word_t mid2;
    } row_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0]          chan;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0]          chan_out;
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          clipped;
    } out_item_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic                idle;
        logic                load;
        logic                mul_init;
        logic                mul_step;
        logic                mul_top;
        logic [DIG_BITS-1:0] dig;
        logic                acc;
        logic                fire;
        logic [OP_BITS-1:0]  op;
    } seq_ctl_t;

    // Saturate a sum to the state width
    function automatic state_word_t sat_state(input logic signed [ACC_BITS-1:0] v);
        logic [ACC_BITS-STATE_BITS:0] hi;
        hi = v[ACC_BITS-1:STATE_BITS-1];
        if ((&hi) || !(|hi))
            return v[STATE_BITS-1:0];
        else if (v[ACC_BITS-1])
            return {1'b1, {(STATE_BITS-1){1'b0}}};
        else
            return {1'b0, {(STATE_BITS-1){1'b1}}};
    endfunction

endpackage

// ===== hdl/bqf_serial_mul.sv =====
// Digit-serial state x coefficient multiplier, coefficient digits LSB first.
// Rounding offset is preloaded so the result is a plain bit slice.
module bqf_serial_mul
    import bqf_pkg::*;
(
    input  logic                        clk,
    input  logic                        init,
    input  logic                        step,
    input  logic                        top,
    input  logic [DIG_BITS-1:0]         dig,
    input  state_word_t                 operand,
    input  coef_t                       coef,
    output logic signed [PROD_BITS-1:0] prod
);

    logic [NDIG-1:0][DIGIT_BITS-1:0]      digits;
    logic [DIGIT_BITS-1:0]                digit;
    logic signed [DIGIT_BITS:0]           dsig;
    logic signed [MUL_T_BITS-1:0]         pp;
    logic signed [MUL_T_BITS-1:0]         sum;
    logic signed [MUL_HI_BITS-1:0]        hi_reg;
    logic [COEF_BITS-1:0]                 lo_reg;
    logic [MUL_HI_BITS+COEF_BITS-1:0]     full;

    // Current digit: unsigned except the top one
    assign digits = coef;
    assign digit  = digits[dig];
    assign dsig   = top ? $signed({digit[DIGIT_BITS-1], digit}) : $signed({1'b0, digit});

    // Partial product and running sum
    assign pp  = MUL_T_BITS'(operand) * MUL_T_BITS'(dsig);
    assign sum = MUL_T_BITS'(hi_reg) + pp;

    // High part stays parallel, low digits shift out into lo_reg
    always_ff @(posedge clk)
    begin
        if (init)
        begin
            hi_reg <= MUL_HI_BITS'(MUL_RND);
            lo_reg <= '0;
        end
        else if (step)
        begin
            hi_reg <= sum[MUL_T_BITS-1:DIGIT_BITS];
            lo_reg <= {sum[DIGIT_BITS-1:0], lo_reg[COEF_BITS-1:DIGIT_BITS]};
        end
    end

    // Drop the fraction bits (round half up via the preload)
    assign full = {hi_reg, lo_reg};
    assign prod = full[COEF_FRAC_BITS +: PROD_BITS];

endmodule

// ===== hdl/bqf_state_mem.sv =====
// Per-channel delay state: one row per channel, registered read,
// valid bit per row so a cleared row reads as zero.
module bqf_state_mem
    import bqf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               rd_en,
    input  logic [CHAN_AW-1:0] rd_addr,
    input  logic               wr_en,
    input  logic [CHAN_AW-1:0] wr_addr,
    input  row_t               wr_row,
    output row_t               rd_row
);

    row_t                mem [CHANNELS];
    row_t                rd_data_reg;
    logic                rd_valid_reg;
    logic [CHANNELS-1:0] valid_reg;

    // Row storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_row;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Valid bits: cleared on reset and on a topology change
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
                valid_reg <= '0;
            else if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/bqf_ctrl.sv =====
// Sequencer: load, then five products of NDIG digit steps plus one
// accumulate step each (none when skipping), then write back and hand off the result.
module bqf_ctrl
    import bqf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     skip,
    input  logic     out_free,
    output seq_ctl_t ctl
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_ACC  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    localparam logic [DIG_BITS-1:0] DIG_LAST = DIG_BITS'(NDIG - 1);
    localparam logic [OP_BITS-1:0]  OP_LAST  = OP_BITS'(NOPS - 1);

    state_t              state_reg, state_next;
    logic [DIG_BITS-1:0] dig_reg, dig_next;
    logic [OP_BITS-1:0]  op_reg, op_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                dig_next   = '0;
                op_next    = '0;
                state_next = skip ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                dig_next = dig_reg + 1'b1;
                if (dig_reg == DIG_LAST)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (op_reg == OP_LAST)
                    state_next = ST_DONE;
                else
                begin
                    op_next    = op_reg + 1'b1;
                    dig_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dig_reg   <= '0;
            op_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dig_reg   <= dig_next;
            op_reg    <= op_next;
        end
    end

    // Controls to the datapath
    always_comb
    begin
        ctl.idle     = (state_reg == ST_IDLE);
        ctl.load     = (state_reg == ST_LOAD);
        ctl.mul_init = ((state_reg == ST_LOAD) && !skip)
                    || ((state_reg == ST_ACC) && (op_reg != OP_LAST));
        ctl.mul_step = (state_reg == ST_MUL);
        ctl.mul_top  = (state_reg == ST_MUL) && (dig_reg == DIG_LAST);
        ctl.dig      = dig_reg;
        ctl.acc      = (state_reg == ST_ACC);
        ctl.fire     = (state_reg == ST_DONE) && out_free;
        ctl.op       = op_reg;
    end

endmodule

// ===== hdl/multichannel_biquad_four_forms.sv =====
// Channel   Signals                                   Moves
// --------  ----------------------------------------  ------------------------------
// in        in_valid, in_stall, in_data               chan, sample_in request
// out       out_valid, out_stall, out_data            chan_out, sample_out, clipped
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data register write request
//
// Each sample runs from accept to the next accept through a load step, five
// products of 4 digit steps plus 1 accumulate step each in the shared digit-serial
// multiplier, a write-back step and an idle step. A channel past CHANNELS skips
// the products. Reset (rst_n, async, low) restores register defaults and clears
// all delay state. A stalled result stays in the output register; the next request
// is still taken and runs until its own write-back, where it waits for the slot.
module multichannel_biquad_four_forms
    import bqf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_item_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_item_t                 out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data
);

    typedef enum logic [3:0] {
        OPND_X, OPND_W, OPND_Y, OPND_IN1, OPND_IN2,
        OPND_OUT1, OPND_OUT2, OPND_MID1, OPND_MID2
    } opnd_t;

    typedef enum logic [2:0] {
        CF_B0, CF_B1, CF_B2, CF_FB1, CF_FB2
    } coef_sel_t;

    typedef enum logic [2:0] {
        BASE_ZERO, BASE_X, BASE_IN1, BASE_IN2, BASE_MID1
    } base_t;

    typedef enum logic [2:0] {
        DST_NONE, DST_W, DST_Y, DST_IN1, DST_IN2, DST_MID1, DST_MID2
    } dest_t;

    typedef struct packed {
        opnd_t     opnd;
        coef_sel_t coef;
        logic      first;
        base_t     base;
        logic      last;
        dest_t     dest;
    } op_ctl_t;

    localparam int YW = STATE_BITS + 1 + TS_RIGHT;

    function automatic op_ctl_t mk_op(input opnd_t o, input coef_sel_t c, input logic f,
                                      input base_t b, input logic l, input dest_t d);
        op_ctl_t r;
        r.opnd  = o;
        r.coef  = c;
        r.first = f;
        r.base  = b;
        r.last  = l;
        r.dest  = d;
        return r;
    endfunction

    // Product schedule per form; base is added at the first product of a sum
    function automatic op_ctl_t op_table(input topo_t t, input logic [OP_BITS-1:0] op);
        op_ctl_t r;
        r = mk_op(OPND_X, CF_B0, 1'b0, BASE_ZERO, 1'b0, DST_NONE);
        unique case (t)
            TOPO_DF1:
            begin
                unique case (op)
                    3'd0: r = mk_op(OPND_X,    CF_B0,  1'b1, BASE_ZERO, 1'b0, DST_NONE);
                    3'd1: r = mk_op(OPND_IN1,  CF_B1,  1'b0, BASE_ZERO, 1'b0, DST_NONE);
                    3'd2: r = mk_op(OPND_IN2,  CF_B2,  1'b0, BASE_ZERO, 1'b0, DST_NONE);
                    3'd3: r = mk_op(OPND_OUT1, CF_FB1, 1'b0, BASE_ZERO, 1'b0, DST_NONE);
                    3'd4: r = mk_op(OPND_OUT2, CF_FB2, 1'b0, BASE_ZERO, 1'b1, DST_Y);
                    default: ;
                endcase
            end
            TOPO_DF2:
            begin
                unique case (op)
                    3'd0: r = mk_op(OPND_MID1, CF_FB1, 1'b1, BASE_X,    1'b0, DST_NONE);
                    3'd1: r = mk_op(OPND_MID2, CF_FB2, 1'b0, BASE_ZERO, 1'b1, DST_W);
                    3'd2: r = mk_op(OPND_W,    CF_B0,  1'b1, BASE_ZERO, 1'b0, DST_NONE);
                    3'd3: r = mk_op(OPND_MID1, CF_B1,  1'b0, BASE_ZERO, 1'b0, DST_NONE);
                    3'd4: r = mk_op(OPND_MID2, CF_B2,  1'b0, BASE_ZERO, 1'b1, DST_Y);
                    default: ;
                endcase
            end
            TOPO_TDF1:
            begin
                unique case (op)
                    3'd0: r = mk_op(OPND_W, CF_B0,  1'b1, BASE_IN2,  1'b1, DST_Y);
                    3'd1: r = mk_op(OPND_W, CF_B1,  1'b1, BASE_IN1,  1'b1, DST_IN2);
                    3'd2: r = mk_op(OPND_W, CF_FB1, 1'b1, BASE_MID1, 1'b1, DST_MID2);
                    3'd3: r = mk_op(OPND_W, CF_B2,  1'b1, BASE_ZERO, 1'b1, DST_IN1);
                    3'd4: r = mk_op(OPND_W, CF_FB2, 1'b1, BASE_ZERO, 1'b1, DST_MID1);
                    default: ;
                endcase
            end
            TOPO_TDF2:
            begin
                unique case (op)
                    3'd0: r = mk_op(OPND_X, CF_B0,  1'b1, BASE_IN2,  1'b1, DST_Y);
                    3'd1: r = mk_op(OPND_X, CF_B1,  1'b1, BASE_IN1,  1'b0, DST_NONE);
                    3'd2: r = mk_op(OPND_Y, CF_FB1, 1'b0, BASE_ZERO, 1'b1, DST_IN2);
                    3'd3: r = mk_op(OPND_X, CF_B2,  1'b1, BASE_ZERO, 1'b0, DST_NONE);
                    3'd4: r = mk_op(OPND_Y, CF_FB2, 1'b0, BASE_ZERO, 1'b1, DST_IN1);
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sample to state format
    function automatic state_word_t to_state(input logic signed [SAMPLE_BITS-1:0] s);
        state_word_t v;
        v = STATE_BITS'(s);
        v = v <<< TS_LEFT;
        v = v >>> TS_RIGHT;
        return v;
    endfunction

    seq_ctl_t                    ctl;
    op_ctl_t                     cur_op;
    row_t                        old_row;
    row_t                        wr_row;
    row_t                        nrow_reg;
    logic [CHAN_BITS-1:0]        chan_reg;
    state_word_t                 x_reg;
    state_word_t                 w_reg;
    state_word_t                 y_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [ACC_BITS-1:0]  acc_sum;
    state_word_t                 acc_sat;
    state_word_t                 base_val;
    state_word_t                 mul_opnd;
    coef_t                       mul_coef;
    logic signed [PROD_BITS-1:0] prod;
    coef_t                       b0_reg, b1_reg, b2_reg, fb1_reg, fb2_reg;
    topo_t                       topo_reg;
    logic                        in_accept;
    logic                        cfg_write;
    logic                        skip;
    logic                        out_free;
    logic                        out_valid_reg;
    out_item_t                   out_reg;
    logic signed [YW-1:0]        y_round;
    logic [YW-SAMPLE_BITS:0]     y_hi;
    logic                        y_fits;
    logic [SAMPLE_BITS-1:0]      y_sample;

    // Handshakes
    assign in_stall  = !ctl.idle;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign skip      = ({1'b0, chan_reg} >= CHAN_LIMIT);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg   <= COEF_ONE;
            b1_reg   <= '0;
            b2_reg   <= '0;
            fb1_reg  <= '0;
            fb2_reg  <= '0;
            topo_reg <= TOPO_TDF2;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_B0:       b0_reg   <= cfg_data;
                CFG_B1:       b1_reg   <= cfg_data;
                CFG_B2:       b2_reg   <= cfg_data;
                CFG_FB1:      fb1_reg  <= cfg_data;
                CFG_FB2:      fb2_reg  <= cfg_data;
                CFG_TOPOLOGY: topo_reg <= topo_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    bqf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_valid),
        .skip     (skip),
        .out_free (out_free),
        .ctl      (ctl)
    );

    bqf_state_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_write && (cfg_index == CFG_TOPOLOGY)),
        .rd_en   (in_accept),
        .rd_addr (in_data.chan[CHAN_AW-1:0]),
        .wr_en   (ctl.fire && !skip),
        .wr_addr (chan_reg[CHAN_AW-1:0]),
        .wr_row  (wr_row),
        .rd_row  (old_row)
    );

    // Operand, coefficient and base selection for the current product
    assign cur_op = op_table(topo_reg, ctl.op);

    always_comb
    begin
        unique case (cur_op.opnd)
            OPND_X:    mul_opnd = x_reg;
            OPND_W:    mul_opnd = w_reg;
            OPND_Y:    mul_opnd = y_reg;
            OPND_IN1:  mul_opnd = old_row.in1;
            OPND_IN2:  mul_opnd = old_row.in2;
            OPND_OUT1: mul_opnd = old_row.out1;
            OPND_OUT2: mul_opnd = old_row.out2;
            OPND_MID1: mul_opnd = old_row.mid1;
            OPND_MID2: mul_opnd = old_row.mid2;
            default:   mul_opnd = x_reg;
        endcase

        unique case (cur_op.coef)
            CF_B0:   mul_coef = b0_reg;
            CF_B1:   mul_coef = b1_reg;
            CF_B2:   mul_coef = b2_reg;
            CF_FB1:  mul_coef = fb1_reg;
            CF_FB2:  mul_coef = fb2_reg;
            default: mul_coef = b0_reg;
        endcase

        unique case (cur_op.base)
            BASE_ZERO: base_val = '0;
            BASE_X:    base_val = x_reg;
            BASE_IN1:  base_val = old_row.in1;
            BASE_IN2:  base_val = old_row.in2;
            BASE_MID1: base_val = old_row.mid1;
            default:   base_val = '0;
        endcase
    end

    bqf_serial_mul u_mul (
        .clk     (clk),
        .init    (ctl.mul_init),
        .step    (ctl.mul_step),
        .top     (ctl.mul_top),
        .dig     (ctl.dig),
        .operand (mul_opnd),
        .coef    (mul_coef),
        .prod    (prod)
    );

    // Accumulate the rounded product
    assign acc_sum = (cur_op.first ? ACC_BITS'(base_val) : acc_reg) + ACC_BITS'(prod);
    assign acc_sat = sat_state(acc_sum);

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            chan_reg <= in_data.chan;
            x_reg    <= to_state(in_data.sample_in);
        end
        if (ctl.load)
        begin
            nrow_reg <= old_row;
            // transposed DF-I input node
            w_reg    <= sat_state(ACC_BITS'(x_reg) + ACC_BITS'(old_row.mid2));
        end
        if (ctl.acc)
        begin
            acc_reg <= acc_sum;
            if (cur_op.last)
            begin
                unique case (cur_op.dest)
                    DST_W:    w_reg         <= acc_sat;
                    DST_Y:    y_reg         <= acc_sat;
                    DST_IN1:  nrow_reg.in1  <= acc_sat;
                    DST_IN2:  nrow_reg.in2  <= acc_sat;
                    DST_MID1: nrow_reg.mid1 <= acc_sat;
                    DST_MID2: nrow_reg.mid2 <= acc_sat;
                    default: ;
                endcase
            end
        end
    end

    // Row written back: direct forms shift their delay lines here
    always_comb
    begin
        wr_row = nrow_reg;
        unique case (topo_reg)
            TOPO_DF1:
            begin
                wr_row.in1  = x_reg;
                wr_row.in2  = old_row.in1;
                wr_row.out1 = y_reg;
                wr_row.out2 = old_row.out1;
            end
            TOPO_DF2:
            begin
                wr_row.mid1 = w_reg;
                wr_row.mid2 = old_row.mid1;
            end
            TOPO_TDF1, TOPO_TDF2:
            begin
                wr_row = nrow_reg;
            end
            default:
            begin
                wr_row = nrow_reg;
            end
        endcase
    end

    // Output rounding and saturation
    always_comb
    begin
        y_round  = (YW'(y_reg) + YW'(TS_RND)) >>> TS_LEFT;
        y_round  = y_round <<< TS_RIGHT;
        y_hi     = y_round[YW-1:SAMPLE_BITS-1];
        y_fits   = (&y_hi) || !(|y_hi);
        if (y_fits)
            y_sample = y_round[SAMPLE_BITS-1:0];
        else if (y_round[YW-1])
            y_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            y_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            out_reg.chan_out   <= chan_reg;
            out_reg.sample_out <= skip ? '0 : y_sample;
            out_reg.clipped    <= skip ? 1'b0 : !y_fits;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
